@@ rtl/quad_motor_mixer_macros.svh @@
// ----------------------------------------------------------------------------
// Quad motor mixer assertion macros
// Shared concurrent assertion forms for the mixer checkers.
// ----------------------------------------------------------------------------
`ifndef QUAD_MOTOR_MIXER_MACROS_SVH
`define QUAD_MOTOR_MIXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quad motor mixer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quad motor mixer assertion failed");

`endif

@@ rtl/qmm_pkg.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer package
// Widths, constants, mixing tables and shared types of the motor mixer.
// ----------------------------------------------------------------------------
package qmm_pkg;

   localparam int MotorCount = 4;
   localparam int MotorIdxW  = $clog2(MotorCount);
   localparam int ChanW      = 3;
   localparam int PulseW     = 11;
   localparam int CmdW       = 32;
   localparam int CmdCount   = 4;
   localparam int SumW       = CmdW + 2;
   localparam int ProdW      = SumW + 10;
   localparam int MaxW       = 27;
   localparam int DemW       = MaxW + 1;
   localparam int ScaleW     = 10;
   localparam int LevelW     = 10;
   localparam int DivNumW    = 20;
   localparam int DivDenW    = MaxW;
   localparam int DivCntW    = $clog2(DivNumW);
   localparam int RoundShift = 16;
   localparam int CsrIdxW    = 2;

   localparam int DemandFull = 1000;
   localparam int ScaleNumer = 1000 * 1000;
   localparam int RoundHalf  = 32768;
   localparam int PulseLow   = 1000;
   localparam int PulseHigh  = 2000;

   localparam logic [ChanW-1:0] LAST_CHANNEL = ChanW'(MotorCount - 1);

   localparam logic [CsrIdxW-1:0] CSR_MIXER_SELECT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_PULSE_MIN    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_PULSE_IDLE   = 2'd2;

   localparam logic MIX_PLUS = 1'b0;
   localparam logic MIX_X    = 1'b1;

   typedef logic [1:0] coef_type;

   localparam coef_type COEF_ZERO = 2'b00;
   localparam coef_type COEF_POS  = 2'b01;
   localparam coef_type COEF_NEG  = 2'b11;

   localparam int CmdThrust = 0;
   localparam int CmdRoll   = 1;
   localparam int CmdPitch  = 2;
   localparam int CmdYaw    = 3;

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] numer;
      logic [DivDenW-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DivNumW-1:0] quot;
   } div_rsp_type;

   // Rows are packed with motor 3 on the left and motor 0 on the right.
   function automatic coef_type mix_coef(input logic sel, input logic [1:0] cmd,
                                         input logic [MotorIdxW-1:0] motor);
      logic [4*2-1:0] row;
      row = {COEF_POS, COEF_POS, COEF_POS, COEF_POS};
      if (sel == MIX_X) begin
         case (cmd)
            2'(CmdThrust): row = {COEF_POS, COEF_POS, COEF_POS, COEF_POS};
            2'(CmdRoll):   row = {COEF_POS, COEF_POS, COEF_NEG, COEF_NEG};
            2'(CmdPitch):  row = {COEF_POS, COEF_NEG, COEF_POS, COEF_NEG};
            2'(CmdYaw):    row = {COEF_POS, COEF_NEG, COEF_NEG, COEF_POS};
            default:       row = {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
         endcase
      end else begin
         case (cmd)
            2'(CmdThrust): row = {COEF_POS, COEF_POS, COEF_POS, COEF_POS};
            2'(CmdRoll):   row = {COEF_ZERO, COEF_POS, COEF_NEG, COEF_ZERO};
            2'(CmdPitch):  row = {COEF_POS, COEF_ZERO, COEF_ZERO, COEF_NEG};
            2'(CmdYaw):    row = {COEF_NEG, COEF_POS, COEF_POS, COEF_NEG};
            default:       row = {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
         endcase
      end
      return row[motor*2 +: 2];
   endfunction

endpackage

@@ rtl/qmm_req_if.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer request channel
// Carries one control command with its armed bit.
// ----------------------------------------------------------------------------
interface qmm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [qmm_pkg::CmdW-1:0]         thrust_cmd;
   logic signed [qmm_pkg::CmdW-1:0]         roll_cmd;
   logic signed [qmm_pkg::CmdW-1:0]         pitch_cmd;
   logic signed [qmm_pkg::CmdW-1:0]         yaw_cmd;
   logic                                    armed;

   modport source (output valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, armed,
                   input ready);
   modport sink (input valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, armed,
                 output ready);
endinterface

@@ rtl/qmm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer result channel
// Carries one motor pulse per transfer.
// ----------------------------------------------------------------------------
interface qmm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [qmm_pkg::ChanW-1:0]   channel;
   logic [qmm_pkg::PulseW-1:0]  pulse_width;
   logic                        last;

   modport source (output valid, channel, pulse_width, last, input ready);
   modport sink (input valid, channel, pulse_width, last, output ready);
endinterface

@@ rtl/qmm_csr_if.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer register write channel
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface qmm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [qmm_pkg::CsrIdxW-1:0]   index;
   logic [qmm_pkg::PulseW-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/quad_motor_mixer.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer
// Mixes one thrust, roll, pitch and yaw command into four motor pulses.
// ----------------------------------------------------------------------------
// The request channel takes one Q16.16 command with an armed bit. The block
// answers with four results on the result channel, one per motor in channel
// order, the last one flagged. The register channel is always ready and
// selects the plus or X table and sets the minimum and idle pulse. It must be
// written only while no request is in flight; the block itself does not
// enforce this. When a motor demand exceeds full scale, the shared 20-bit
// restoring divider, one quotient bit per cycle, forms the scale factor
// once and then each positive scaled motor value in turn. The block takes
// no new request until the last result sits in the output register. A
// stalled receiver holds that register and the mixer waits before loading
// the next result. Reset empties the output register, returns to idle and
// restores the register defaults.
// ----------------------------------------------------------------------------
module quad_motor_mixer (
   input  logic         clock,
   input  logic         reset,
   qmm_req_if.sink      req_ch,
   qmm_rsp_if.source    rsp_ch,
   qmm_csr_if.sink      csr_ch
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MIX       = 4'd1;
   localparam logic [3:0] ST_MUL       = 4'd2;
   localparam logic [3:0] ST_RND       = 4'd3;
   localparam logic [3:0] ST_STORE     = 4'd4;
   localparam logic [3:0] ST_SDIV_GO   = 4'd5;
   localparam logic [3:0] ST_SDIV_WAIT = 4'd6;
   localparam logic [3:0] ST_PMUL      = 4'd7;
   localparam logic [3:0] ST_PDIV_GO   = 4'd8;
   localparam logic [3:0] ST_PDIV_WAIT = 4'd9;
   localparam logic [3:0] ST_PULSE     = 4'd10;

   localparam int PulseSumW = qmm_pkg::PulseW + 1;

   logic [3:0] state_ff, state_in;

   logic                              mixer_sel_ff, mixer_sel_in;
   logic [qmm_pkg::PulseW-1:0]        pulse_min_ff, pulse_min_in;
   logic [qmm_pkg::PulseW-1:0]        pulse_idle_ff, pulse_idle_in;

   logic signed [qmm_pkg::CmdW-1:0]   cmd_ff [qmm_pkg::CmdCount];
   logic signed [qmm_pkg::CmdW-1:0]   cmd_in [qmm_pkg::CmdCount];
   logic                              armed_ff, armed_in;
   logic [qmm_pkg::MotorIdxW-1:0]     motor_ff, motor_in;
   logic signed [qmm_pkg::SumW-1:0]   sum_ff, sum_in;
   logic signed [qmm_pkg::ProdW-1:0]  prod_ff, prod_in;
   logic [qmm_pkg::MaxW-1:0]          rmag_ff, rmag_in;
   logic                              rneg_ff, rneg_in;
   logic signed [qmm_pkg::DemW-1:0]   demand_ff [qmm_pkg::MotorCount];
   logic signed [qmm_pkg::DemW-1:0]   demand_in [qmm_pkg::MotorCount];
   logic [qmm_pkg::MaxW-1:0]          max_ff, max_in;
   logic                              scaled_ff, scaled_in;
   logic [qmm_pkg::ScaleW-1:0]        scale_ff, scale_in;
   logic [qmm_pkg::DivNumW-1:0]       sprod_ff, sprod_in;
   logic [qmm_pkg::LevelW-1:0]        level_ff, level_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [qmm_pkg::ChanW-1:0]         rsp_channel_ff, rsp_channel_in;
   logic [qmm_pkg::PulseW-1:0]        rsp_pulse_ff, rsp_pulse_in;
   logic                              rsp_last_ff, rsp_last_in;

   qmm_pkg::div_req_type              div_req;
   qmm_pkg::div_rsp_type              div_rsp;

   logic                              req_accept;
   logic                              out_free;
   logic signed [qmm_pkg::SumW-1:0]   mix_sum;
   logic [qmm_pkg::ProdW-1:0]         mag;
   logic [qmm_pkg::ProdW-1:0]         mag_rnd;
   logic signed [qmm_pkg::DemW-1:0]   demand_new;
   logic signed [qmm_pkg::DemW-1:0]   demand_cur;
   logic                              demand_pos;
   logic [qmm_pkg::MaxW+qmm_pkg::ScaleW-1:0] scaled_prod;
   logic [PulseSumW-1:0]              pulse_sum;
   logic [PulseSumW-1:0]              pulse_run;
   logic [qmm_pkg::PulseW-1:0]        pulse_out;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      mix_sum = '0;
      for (int k = 0; k < qmm_pkg::CmdCount; k++) begin
         case (qmm_pkg::mix_coef(mixer_sel_ff, 2'(k), motor_ff))
            qmm_pkg::COEF_POS: mix_sum = mix_sum + qmm_pkg::SumW'(cmd_ff[k]);
            qmm_pkg::COEF_NEG: mix_sum = mix_sum - qmm_pkg::SumW'(cmd_ff[k]);
            default:           mix_sum = mix_sum;
         endcase
      end
   end

   assign mag        = prod_ff[qmm_pkg::ProdW-1] ? qmm_pkg::ProdW'(-prod_ff)
                                                 : qmm_pkg::ProdW'(prod_ff);
   assign mag_rnd    = mag + qmm_pkg::ProdW'(qmm_pkg::RoundHalf);
   assign demand_new = rneg_ff ? -$signed({1'b0, rmag_ff}) : $signed({1'b0, rmag_ff});
   assign demand_cur = demand_ff[motor_ff];
   assign demand_pos = !demand_cur[qmm_pkg::DemW-1] && (demand_cur != '0);
   assign scaled_prod = demand_cur[qmm_pkg::MaxW-1:0] * scale_ff;

   always_comb begin
      pulse_sum = PulseSumW'(level_ff) + PulseSumW'(pulse_min_ff);
      pulse_run = pulse_sum;
      if (pulse_sum < PulseSumW'(pulse_idle_ff)) begin
         pulse_run = PulseSumW'(pulse_idle_ff);
      end
      if (!armed_ff) begin
         pulse_out = pulse_min_ff;
      end else if (pulse_run < PulseSumW'(qmm_pkg::PulseLow)) begin
         pulse_out = qmm_pkg::PulseW'(qmm_pkg::PulseLow);
      end else if (pulse_run > PulseSumW'(qmm_pkg::PulseHigh)) begin
         pulse_out = qmm_pkg::PulseW'(qmm_pkg::PulseHigh);
      end else begin
         pulse_out = pulse_run[qmm_pkg::PulseW-1:0];
      end
   end

   always_comb begin
      div_req.start = 1'b0;
      div_req.numer = sprod_ff;
      div_req.denom = qmm_pkg::DivDenW'(qmm_pkg::DemandFull);
      if (state_ff == ST_SDIV_GO) begin
         div_req.start = max_ff > qmm_pkg::MaxW'(qmm_pkg::DemandFull);
         div_req.numer = qmm_pkg::DivNumW'(qmm_pkg::ScaleNumer);
         div_req.denom = max_ff;
      end else if (state_ff == ST_PDIV_GO) begin
         div_req.start = 1'b1;
      end
   end

   qmm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      mixer_sel_in  = mixer_sel_ff;
      pulse_min_in  = pulse_min_ff;
      pulse_idle_in = pulse_idle_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            qmm_pkg::CSR_MIXER_SELECT: mixer_sel_in  = csr_ch.data[0];
            qmm_pkg::CSR_PULSE_MIN:    pulse_min_in  = csr_ch.data;
            qmm_pkg::CSR_PULSE_IDLE:   pulse_idle_in = csr_ch.data;
            default:                   mixer_sel_in  = mixer_sel_ff;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      armed_in       = armed_ff;
      motor_in       = motor_ff;
      sum_in         = sum_ff;
      prod_in        = prod_ff;
      rmag_in        = rmag_ff;
      rneg_in        = rneg_ff;
      demand_in      = demand_ff;
      max_in         = max_ff;
      scaled_in      = scaled_ff;
      scale_in       = scale_ff;
      sprod_in       = sprod_ff;
      level_in       = level_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_channel_in = rsp_channel_ff;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in[qmm_pkg::CmdThrust] = req_ch.thrust_cmd;
               cmd_in[qmm_pkg::CmdRoll]   = req_ch.roll_cmd;
               cmd_in[qmm_pkg::CmdPitch]  = req_ch.pitch_cmd;
               cmd_in[qmm_pkg::CmdYaw]    = req_ch.yaw_cmd;
               armed_in = req_ch.armed;
               motor_in = '0;
               max_in   = qmm_pkg::MaxW'(qmm_pkg::DemandFull);
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            sum_in   = mix_sum;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = sum_ff * $signed(qmm_pkg::ProdW'(qmm_pkg::DemandFull));
            state_in = ST_RND;
         end
         ST_RND: begin
            rmag_in  = mag_rnd[qmm_pkg::RoundShift +: qmm_pkg::MaxW];
            rneg_in  = prod_ff[qmm_pkg::ProdW-1];
            state_in = ST_STORE;
         end
         ST_STORE: begin
            demand_in[motor_ff] = demand_new;
            if (!rneg_ff && (rmag_ff > max_ff)) begin
               max_in = rmag_ff;
            end
            motor_in = motor_ff + 1'b1;
            if (motor_ff == qmm_pkg::MotorIdxW'(qmm_pkg::MotorCount - 1)) begin
               state_in = ST_SDIV_GO;
            end else begin
               state_in = ST_MIX;
            end
         end
         ST_SDIV_GO: begin
            if (max_ff > qmm_pkg::MaxW'(qmm_pkg::DemandFull)) begin
               state_in = ST_SDIV_WAIT;
            end else begin
               scaled_in = 1'b0;
               state_in  = ST_PMUL;
            end
         end
         ST_SDIV_WAIT: begin
            if (div_rsp.done) begin
               scale_in  = div_rsp.quot[qmm_pkg::ScaleW-1:0];
               scaled_in = 1'b1;
               state_in  = ST_PMUL;
            end
         end
         ST_PMUL: begin
            if (!scaled_ff) begin
               level_in = demand_cur[qmm_pkg::DemW-1] ? '0
                                                      : demand_cur[qmm_pkg::LevelW-1:0];
               state_in = ST_PULSE;
            end else if (!demand_pos) begin
               level_in = '0;
               state_in = ST_PULSE;
            end else begin
               sprod_in = scaled_prod[qmm_pkg::DivNumW-1:0];
               state_in = ST_PDIV_GO;
            end
         end
         ST_PDIV_GO: begin
            state_in = ST_PDIV_WAIT;
         end
         ST_PDIV_WAIT: begin
            if (div_rsp.done) begin
               level_in = div_rsp.quot[qmm_pkg::LevelW-1:0];
               state_in = ST_PULSE;
            end
         end
         ST_PULSE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = qmm_pkg::ChanW'(motor_ff);
               rsp_pulse_in   = pulse_out;
               rsp_last_in    = (motor_ff == qmm_pkg::MotorIdxW'(qmm_pkg::MotorCount - 1));
               motor_in       = motor_ff + 1'b1;
               state_in       = rsp_last_in ? ST_IDLE : ST_PMUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         mixer_sel_ff  <= qmm_pkg::MIX_PLUS;
         pulse_min_ff  <= qmm_pkg::PulseW'(qmm_pkg::PulseLow);
         pulse_idle_ff <= qmm_pkg::PulseW'(qmm_pkg::PulseLow);
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         mixer_sel_ff  <= mixer_sel_in;
         pulse_min_ff  <= pulse_min_in;
         pulse_idle_ff <= pulse_idle_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      armed_ff       <= armed_in;
      motor_ff       <= motor_in;
      sum_ff         <= sum_in;
      prod_ff        <= prod_in;
      rmag_ff        <= rmag_in;
      rneg_ff        <= rneg_in;
      demand_ff      <= demand_in;
      max_ff         <= max_in;
      scaled_ff      <= scaled_in;
      scale_ff       <= scale_in;
      sprod_ff       <= sprod_in;
      level_ff       <= level_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.channel     = rsp_channel_ff;
   assign rsp_ch.pulse_width = rsp_pulse_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

@@ rtl/qmm_div.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qmm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  qmm_pkg::div_req_type  div_req,
   output qmm_pkg::div_rsp_type  div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [qmm_pkg::DivCntW-1:0]   cnt_ff, cnt_in;
   logic [qmm_pkg::DivDenW-1:0]   rem_ff, rem_in;
   logic [qmm_pkg::DivNumW-1:0]   num_ff, num_in;
   logic [qmm_pkg::DivDenW-1:0]   den_ff, den_in;
   logic [qmm_pkg::DivNumW-1:0]   quo_ff, quo_in;
   logic [qmm_pkg::DivDenW:0]     trial;
   logic [qmm_pkg::DivDenW:0]     diff;
   logic                          fits;

   assign trial = {rem_ff, num_ff[qmm_pkg::DivNumW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = div_req.numer;
         den_in  = div_req.denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[qmm_pkg::DivDenW-1:0] : trial[qmm_pkg::DivDenW-1:0];
         num_in = {num_ff[qmm_pkg::DivNumW-2:0], 1'b0};
         quo_in = {quo_ff[qmm_pkg::DivNumW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == qmm_pkg::DivCntW'(qmm_pkg::DivNumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

@@ rtl/qmm_checker.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer checker
// Port-level assertions on the mixer channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "quad_motor_mixer_macros.svh"

module qmm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [qmm_pkg::ChanW-1:0]   rsp_channel,
   input logic [qmm_pkg::PulseW-1:0]  rsp_pulse_width,
   input logic                        rsp_last
);

   // A stalled result keeps its contents.
   `QMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel) && $stable(rsp_pulse_width) && $stable(rsp_last))

   // Only the last motor of a request carries the last flag.
   `QMM_ASSERT_IMPLY(a_last_channel, clock, reset, rsp_valid, rsp_last == (rsp_channel == qmm_pkg::LAST_CHANNEL))

   // An accepted request keeps the mixer busy in the next cycle.
   `QMM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // No new request is taken while a request still has results to give.
   `QMM_ASSERT_IMPLY(a_busy_mid_cmd, clock, reset, rsp_valid && !rsp_last, !req_ready)

endmodule

bind quad_motor_mixer qmm_checker u_qmm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_channel     (rsp_ch.channel),
   .rsp_pulse_width (rsp_ch.pulse_width),
   .rsp_last        (rsp_ch.last)
);

@@ sim/tb_quad_motor_mixer.sv @@
// ----------------------------------------------------------------------------
// Quad motor mixer testbench
// Drives mixer commands through the request channel under several register
// settings, predicts the four motor pulses of each request and checks every
// result in order, with random idle cycles on both channels.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [qmm_pkg::CmdW-1:0] thrust;
   logic signed [qmm_pkg::CmdW-1:0] roll;
   logic signed [qmm_pkg::CmdW-1:0] pitch;
   logic signed [qmm_pkg::CmdW-1:0] yaw;
   logic                            armed;
} mix_cmd_t;

typedef struct {
   logic [qmm_pkg::ChanW-1:0]  channel;
   logic [qmm_pkg::PulseW-1:0] pulse_width;
   logic                       last;
} motor_pulse_t;

class motor_pulse_board;
   int             weight[2][4][4];
   logic           x_mode;
   int             pulse_min;
   int             pulse_idle;
   motor_pulse_t   pulse_queue[$];
   int             errors;
   int             checked;

   function new();
      // Indexed by table, then thrust, roll, pitch, yaw, then motor.
      weight = '{'{'{1, 1, 1, 1}, '{0, -1, 1, 0}, '{-1, 0, 0, 1}, '{-1, 1, 1, -1}},
                 '{'{1, 1, 1, 1}, '{-1, -1, 1, 1}, '{-1, 1, -1, 1}, '{1, -1, -1, 1}}};
      x_mode     = qmm_pkg::MIX_PLUS;
      pulse_min  = 1000;
      pulse_idle = 1000;
      errors     = 0;
      checked    = 0;
   endfunction

   function void set_register(logic [qmm_pkg::CsrIdxW-1:0] idx,
                              logic [qmm_pkg::PulseW-1:0] data);
      case (idx)
         qmm_pkg::CSR_MIXER_SELECT: x_mode = data[0];
         qmm_pkg::CSR_PULSE_MIN:    pulse_min = int'(data);
         qmm_pkg::CSR_PULSE_IDLE:   pulse_idle = int'(data);
         default: ;
      endcase
   endfunction

   function void note_command(mix_cmd_t c);
      longint       cmd[4];
      longint       demand[4];
      longint       sum;
      longint       prod;
      longint       peak;
      longint       scale;
      longint       level;
      longint       pulse;
      motor_pulse_t p;
      cmd[0] = longint'(c.thrust);
      cmd[1] = longint'(c.roll);
      cmd[2] = longint'(c.pitch);
      cmd[3] = longint'(c.yaw);
      peak = qmm_pkg::DemandFull;
      for (int m = 0; m < 4; m++) begin
         sum = 0;
         for (int k = 0; k < 4; k++) sum += cmd[k] * longint'(weight[x_mode][k][m]);
         prod = sum * 1000;
         if (prod >= 0) demand[m] = (prod + 32768) / 65536;
         else demand[m] = -((-prod + 32768) / 65536);
         if (demand[m] > peak) peak = demand[m];
      end
      scale = (peak > qmm_pkg::DemandFull) ? longint'(qmm_pkg::ScaleNumer) / peak : 1000;
      for (int m = 0; m < 4; m++) begin
         level = demand[m] * scale / 1000;
         if (level < 0) level = 0;
         if (level > 1000) level = 1000;
         level += pulse_min;
         if (level < pulse_idle) level = pulse_idle;
         if (c.armed) begin
            pulse = level;
            if (pulse < qmm_pkg::PulseLow) pulse = qmm_pkg::PulseLow;
            if (pulse > qmm_pkg::PulseHigh) pulse = qmm_pkg::PulseHigh;
         end else begin
            pulse = pulse_min;
         end
         p.channel     = qmm_pkg::ChanW'(m);
         p.pulse_width = qmm_pkg::PulseW'(pulse);
         p.last        = (m == 3);
         pulse_queue.push_back(p);
      end
   endfunction

   function void check_pulse(logic [qmm_pkg::ChanW-1:0] channel,
                             logic [qmm_pkg::PulseW-1:0] pulse_width, logic last);
      motor_pulse_t want;
      checked++;
      if (pulse_queue.size() == 0) begin
         $display("%0t: unexpected pulse ch %0d width %0d last %0d", $time,
                  channel, pulse_width, last);
         errors++;
         return;
      end
      want = pulse_queue.pop_front();
      if (channel !== want.channel) begin
         $display("%0t: channel expected %0d actual %0d", $time, want.channel, channel);
         errors++;
      end
      if (pulse_width !== want.pulse_width) begin
         $display("%0t: pulse_width on ch %0d expected %0d actual %0d", $time,
                  want.channel, want.pulse_width, pulse_width);
         errors++;
      end
      if (last !== want.last) begin
         $display("%0t: last on ch %0d expected %0d actual %0d", $time,
                  want.channel, want.last, last);
         errors++;
      end
   endfunction

   function int pending();
      return pulse_queue.size();
   endfunction
endclass

module tb_quad_motor_mixer;
   import qmm_pkg::*;

   logic clock = 1'b0;
   logic reset;

   qmm_req_if req_if();
   qmm_rsp_if rsp_if();
   qmm_csr_if csr_if();

   motor_pulse_board board = new();

   int sent_count = 0;
   int setting_count = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   quad_motor_mixer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #2 clock = ~clock;

   function automatic mix_cmd_t make_cmd(int t, int r, int p, int y, logic a);
      mix_cmd_t c;
      c.thrust = t;
      c.roll   = r;
      c.pitch  = p;
      c.yaw    = y;
      c.armed  = a;
      return c;
   endfunction

   function automatic mix_cmd_t random_cmd();
      mix_cmd_t c;
      int       shape;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         c = make_cmd($urandom, $urandom, $urandom, $urandom, 1'b1);
      end else if (shape == 1) begin
         c = make_cmd($urandom_range(65536, 131072), int'($urandom_range(0, 65536)) - 32768,
                      int'($urandom_range(0, 65536)) - 32768,
                      int'($urandom_range(0, 32768)) - 16384, 1'b1);
      end else begin
         c = make_cmd($urandom_range(0, 72000), int'($urandom_range(0, 40000)) - 20000,
                      int'($urandom_range(0, 40000)) - 20000,
                      int'($urandom_range(0, 20000)) - 10000, 1'b1);
      end
      c.armed = ($urandom_range(0, 7) != 0);
      return c;
   endfunction

   task automatic send_cmd(input mix_cmd_t c);
      int gap;
      if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.thrust_cmd <= c.thrust;
      req_if.roll_cmd   <= c.roll;
      req_if.pitch_cmd  <= c.pitch;
      req_if.yaw_cmd    <= c.yaw;
      req_if.armed      <= c.armed;
      do @(posedge clock); while (!req_if.ready);
      board.note_command(c);
      sent_count++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic sel, input logic [PulseW-1:0] pmin,
                                 input logic [PulseW-1:0] pidle);
      logic [CsrIdxW-1:0] idx[3];
      logic [PulseW-1:0]  val[3];
      idx = '{CSR_MIXER_SELECT, CSR_PULSE_MIN, CSR_PULSE_IDLE};
      val = '{PulseW'(sel), pmin, pidle};
      for (int i = 0; i < 3; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx[i];
         csr_if.data  <= val[i];
         do @(posedge clock); while (!csr_if.ready);
         board.set_register(idx[i], val[i]);
      end
      csr_if.valid <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         board.check_pulse(rsp_if.channel, rsp_if.pulse_width, rsp_if.last);
      end
   end

   initial begin
      logic sel_list[6];
      int   min_list[6];
      int   idle_list[6];
      sel_list  = '{MIX_X, MIX_PLUS, MIX_X, MIX_PLUS, MIX_X, MIX_PLUS};
      min_list  = '{1000, 0, 2000, 500, 2047, 900};
      idle_list = '{1100, 0, 2000, 2047, 500, 1200};
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.thrust_cmd <= '0;
      req_if.roll_cmd   <= '0;
      req_if.pitch_cmd  <= '0;
      req_if.yaw_cmd    <= '0;
      req_if.armed      <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_MIXER_SELECT;
      csr_if.data       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset register values.
      send_cmd(make_cmd(0, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(0, 0, 0, 0, 1'b0));
      send_cmd(make_cmd(65536, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(65537, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(65570, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(4096, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(-4096, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(0, 4096, 0, 0, 1'b1));
      send_cmd(make_cmd(32768, 16384, -16384, 8192, 1'b1));
      send_cmd(make_cmd(32'h7FFFFFFF, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(32'h80000000, 0, 0, 0, 1'b1));
      send_cmd(make_cmd(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
      send_cmd(make_cmd(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
      send_cmd(make_cmd(0, 32'h7FFFFFFF, 0, 0, 1'b1));
      send_cmd(make_cmd(0, 0, 32'h7FFFFFFF, 0, 1'b1));
      send_cmd(make_cmd(0, 0, 0, 32'h7FFFFFFF, 1'b1));
      send_cmd(make_cmd(0, 0, 0, 32'h80000000, 1'b1));
      send_cmd(make_cmd(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1));
      send_cmd(make_cmd(98304, 0, 0, 0, 1'b0));
      send_cmd(make_cmd(98304, 32768, 0, 0, 1'b1));
      send_cmd(make_cmd(-1, -1, -1, -1, 1'b1));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_settings(sel_list[ph], PulseW'(min_list[ph]), PulseW'(idle_list[ph]));
         for (int i = 0; i < 37; i++) begin
            send_cmd(random_cmd());
            if ((ph == 0 && i == 10) || $urandom_range(0, 24) == 0) drain();
         end
         drain();
      end

      repeat (150) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0t: %0d expected pulses never arrived", $time, board.pending());
         board.errors++;
      end
      $display("Mixed %0d commands under %0d register settings, both tables included.",
               sent_count, setting_count + 1);
      $display("Checked %0d motor pulses, %0d mismatches.", board.checked, board.errors);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d pulses outstanding.", board.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
